/* rtl/lskc_pkg.sv */
// Package for the letter-shift key cipher: widths, ASCII bounds, register
// indexes, the configuration struct and the mod-26 reduction.
// No dependencies.
package lskc_pkg;

  localparam int unsigned KEY_MAX_DEF = 16;
  localparam int unsigned KEY_SLOTS   = 16;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned ENTRY_W     = 6;
  localparam int unsigned SHIFTS_W    = 48;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned ALPHA_W     = 5;

  localparam logic [6:0]        ALPHA_N  = 7'd26;
  localparam logic [7:0]        WRAP_BIAS = 8'sd52;
  localparam logic [BYTE_W-1:0] CHR_LC_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHR_LC_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CHR_UC_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHR_UC_Z = 8'h5A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DECRYPT_MODE    = 2'd0,
    REG_KEY_LENGTH      = 2'd1,
    REG_KEY_SHIFTS_LOW  = 2'd2,
    REG_KEY_SHIFTS_HIGH = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  decrypt;
    logic [LEN_W-1:0]      key_length;
    logic [2*SHIFTS_W-1:0] key_shifts;
  } cfg_t;

  // value 0..109 reduced modulo 26
  function automatic logic [ALPHA_W-1:0] mod26(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= ALPHA_N) begin
        r = r - ALPHA_N;
      end
    end
    return r[ALPHA_W-1:0];
  endfunction

endpackage

/* rtl/lskc_ifs.sv */
// Valid/ready channel interfaces for the cipher: text in, text out, config.
// Depends on lskc_pkg.
interface lskc_in_if;
  logic                        valid;
  logic                        ready;
  logic [lskc_pkg::BYTE_W-1:0] in_byte;
  logic                        restart;
  modport source(output valid, in_byte, restart, input ready);
  modport sink(input valid, in_byte, restart, output ready);
endinterface

interface lskc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lskc_pkg::BYTE_W-1:0] out_byte;
  modport source(output valid, out_byte, input ready);
  modport sink(input valid, out_byte, output ready);
endinterface

interface lskc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lskc_pkg::CFG_IDX_W-1:0]  index;
  logic [lskc_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/lskc_cfg_regs.sv */
// Configuration register bank: mode, key length and the packed key entries.
// Depends on lskc_pkg and lskc_ifs.
module lskc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  lskc_cfg_if.sink       cfg_ch,
  output lskc_pkg::cfg_t cfg
);

  logic                              decrypt_r;
  logic [lskc_pkg::LEN_W-1:0]        key_length_r;
  logic [lskc_pkg::SHIFTS_W-1:0]     shifts_lo_r;
  logic [lskc_pkg::SHIFTS_W-1:0]     shifts_hi_r;
  lskc_pkg::cfg_reg_t                idx;

  assign cfg_ch.ready = 1'b1;
  assign idx          = lskc_pkg::cfg_reg_t'(cfg_ch.index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_r    <= 1'b0;
      key_length_r <= lskc_pkg::LEN_W'(1);
      shifts_lo_r  <= '0;
      shifts_hi_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (idx)
        lskc_pkg::REG_DECRYPT_MODE:    decrypt_r    <= cfg_ch.data[0];
        lskc_pkg::REG_KEY_LENGTH:      key_length_r <= cfg_ch.data[lskc_pkg::LEN_W-1:0];
        lskc_pkg::REG_KEY_SHIFTS_LOW:  shifts_lo_r  <= cfg_ch.data[lskc_pkg::SHIFTS_W-1:0];
        lskc_pkg::REG_KEY_SHIFTS_HIGH: shifts_hi_r  <= cfg_ch.data[lskc_pkg::SHIFTS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.decrypt    = decrypt_r;
  assign cfg.key_length = key_length_r;
  assign cfg.key_shifts = {shifts_hi_r, shifts_lo_r};

endmodule

/* rtl/lskc_shift_core.sv */
// Single-pass datapath: letter detect, key entry select, add/subtract and
// mod-26 wrap, plus next key position. Depends on lskc_pkg.
module lskc_shift_core #(
  parameter int unsigned KEY_MAX = lskc_pkg::KEY_MAX_DEF
) (
  input  lskc_pkg::cfg_t               cfg,
  input  logic [lskc_pkg::BYTE_W-1:0]  byte_in,
  input  logic [lskc_pkg::POS_W-1:0]   pos_in,
  output logic [lskc_pkg::BYTE_W-1:0]  byte_out,
  output logic                         is_letter,
  output logic [lskc_pkg::POS_W-1:0]   pos_next
);

  localparam logic [lskc_pkg::LEN_W-1:0] LEN_CAP = lskc_pkg::LEN_W'(KEY_MAX);

  logic                               is_lower;
  logic                               is_upper;
  logic [lskc_pkg::BYTE_W-1:0]        base;
  logic [lskc_pkg::LEN_W-1:0]         len_eff;
  logic [lskc_pkg::POS_W-1:0]         pos_use;
  logic [lskc_pkg::LEN_W-1:0]         pos_inc;
  logic [lskc_pkg::ENTRY_W-1:0]       entries [lskc_pkg::KEY_SLOTS];
  logic signed [7:0]                  shift;
  logic signed [7:0]                  sum;
  logic [lskc_pkg::ALPHA_W-1:0]       wrapped;

  assign is_lower  = (byte_in >= lskc_pkg::CHR_LC_A) && (byte_in <= lskc_pkg::CHR_LC_Z);
  assign is_upper  = (byte_in >= lskc_pkg::CHR_UC_A) && (byte_in <= lskc_pkg::CHR_UC_Z);
  assign is_letter = is_lower || is_upper;
  assign base      = is_lower ? lskc_pkg::CHR_LC_A : lskc_pkg::CHR_UC_A;

  always_comb begin
    if (cfg.key_length == '0) begin
      len_eff = lskc_pkg::LEN_W'(1);
    end else if (cfg.key_length > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = cfg.key_length;
    end
  end

  // stale position after a shorter key length falls back to entry 0
  assign pos_use = ({1'b0, pos_in} >= len_eff) ? '0 : pos_in;
  assign pos_inc = {1'b0, pos_use} + lskc_pkg::LEN_W'(1);
  assign pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[lskc_pkg::POS_W-1:0];

  always_comb begin
    for (int i = 0; i < lskc_pkg::KEY_SLOTS; i++) begin
      entries[i] = cfg.key_shifts[i*lskc_pkg::ENTRY_W +: lskc_pkg::ENTRY_W];
    end
  end

  always_comb begin
    shift = 8'(signed'(entries[pos_use]));
    if (cfg.decrypt) begin
      shift = -shift;
    end
    // offset 0..25 plus shift -32..32 plus bias stays within 20..109
    sum     = signed'(byte_in - base) + shift + signed'(lskc_pkg::WRAP_BIAS);
    wrapped = lskc_pkg::mod26(sum[6:0]);
  end

  assign byte_out = is_letter ? (base + lskc_pkg::BYTE_W'(wrapped)) : byte_in;

endmodule

/* rtl/letter_shift_key_cipher_unit.sv */
// Letter-shift key cipher, top level. Depends on lskc_pkg, lskc_ifs,
// lskc_cfg_regs and lskc_shift_core.
// A beat passes the input register, then the result register.
// Throughput: one byte per cycle unless the output stalls.
// Reset (rst_n low, synchronous): both stages empty, key position 0,
// decrypt off, key length 1, all key entries 0.
module letter_shift_key_cipher_unit #(
  parameter int unsigned KEY_MAX = lskc_pkg::KEY_MAX_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lskc_in_if.sink    in_ch,
  lskc_out_if.source out_ch,
  lskc_cfg_if.sink   cfg_ch
);

  lskc_pkg::cfg_t                  cfg;
  logic                            s1_valid_r;
  logic [lskc_pkg::BYTE_W-1:0]     s1_byte_r;
  logic                            s1_restart_r;
  logic                            out_valid_r;
  logic [lskc_pkg::BYTE_W-1:0]     out_byte_r;
  logic [lskc_pkg::POS_W-1:0]      key_pos_r;
  logic [lskc_pkg::POS_W-1:0]      key_pos_nxt;
  logic [lskc_pkg::POS_W-1:0]      pos_cur;
  logic [lskc_pkg::POS_W-1:0]      pos_adv;
  logic [lskc_pkg::BYTE_W-1:0]     res_byte;
  logic                            is_letter;
  logic                            s1_adv;
  logic                            in_take;

  lskc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign pos_cur = s1_restart_r ? '0 : key_pos_r;

  lskc_shift_core #(.KEY_MAX(KEY_MAX)) u_core (
    .cfg       (cfg),
    .byte_in   (s1_byte_r),
    .pos_in    (pos_cur),
    .byte_out  (res_byte),
    .is_letter (is_letter),
    .pos_next  (pos_adv)
  );

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign key_pos_nxt = is_letter ? pos_adv : pos_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_pos_r   <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        key_pos_r   <= key_pos_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r    <= in_ch.in_byte;
      s1_restart_r <= in_ch.restart;
    end
    if (s1_adv) begin
      out_byte_r <= res_byte;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  a_nonletter_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !is_letter) |=> (out_byte_r == $past(s1_byte_r)))
    else $error("non-letter beat altered");

  a_nonletter_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !is_letter && !s1_restart_r) |=> $stable(key_pos_r))
    else $error("key position moved on a non-letter");

  a_lower_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_byte_r >= lskc_pkg::CHR_LC_A && s1_byte_r <= lskc_pkg::CHR_LC_Z)
      |=> (out_byte_r >= lskc_pkg::CHR_LC_A && out_byte_r <= lskc_pkg::CHR_LC_Z))
    else $error("lower-case letter left its range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

endmodule

/* test/tb_letter_shift_key_cipher_unit.sv */
// Testbench for letter_shift_key_cipher_unit: directed and random text through many key
// settings, each output beat checked against an in-bench cipher tracker.
// Depends on lskc_pkg, the lskc_ifs interfaces and the RTL.
import lskc_pkg::*;

class cipher_ledger;
  logic                  decrypt;
  logic [LEN_W-1:0]      key_len;
  logic [2*SHIFTS_W-1:0] shifts;
  logic [POS_W-1:0]      key_pos;
  logic [BYTE_W-1:0]     expected_text[$];
  int unsigned           mismatches;
  int unsigned           checked;

  function new();
    decrypt    = 1'b0;
    key_len    = LEN_W'(1);
    shifts     = '0;
    key_pos    = '0;
    mismatches = 0;
    checked    = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DECRYPT_MODE:    decrypt = data[0];
      REG_KEY_LENGTH:      key_len = data[LEN_W-1:0];
      REG_KEY_SHIFTS_LOW:  shifts[SHIFTS_W-1:0] = data;
      REG_KEY_SHIFTS_HIGH: shifts[2*SHIFTS_W-1:SHIFTS_W] = data;
      default: ;
    endcase
  endfunction

  function logic [BYTE_W-1:0] cipher_byte(logic [BYTE_W-1:0] b, logic restart);
    logic [BYTE_W-1:0] base;
    int unsigned       span;
    int unsigned       slot;
    int                shift;
    int                v;
    if (restart) key_pos = '0;
    if (b >= CHR_LC_A && b <= CHR_LC_Z) base = CHR_LC_A;
    else if (b >= CHR_UC_A && b <= CHR_UC_Z) base = CHR_UC_A;
    else return b;
    span = (key_len == 0) ? 1 : (key_len > KEY_MAX_DEF) ? KEY_MAX_DEF : key_len;
    slot = (key_pos >= span) ? 0 : key_pos;
    shift = $signed(shifts[slot*ENTRY_W +: ENTRY_W]);
    if (decrypt) shift = -shift;
    v = int'(b - base) + shift + 78;
    key_pos = POS_W'((slot + 1 >= span) ? 0 : slot + 1);
    return base + BYTE_W'(v % 26);
  endfunction

  function void note_input(logic [BYTE_W-1:0] b, logic restart);
    expected_text.push_back(cipher_byte(b, restart));
  endfunction

  function void check_result(logic [BYTE_W-1:0] got);
    logic [BYTE_W-1:0] want;
    if (expected_text.size() == 0) begin
      $error("out_byte: expected nothing, actual 0x%02h", got);
      mismatches++;
      return;
    end
    want = expected_text.pop_front();
    checked++;
    if (got !== want) begin
      $error("out_byte: expected 0x%02h, actual 0x%02h", want, got);
      mismatches++;
    end
  endfunction

  function int unsigned pending();
    return expected_text.size();
  endfunction
endclass

module tb_letter_shift_key_cipher_unit;

  logic clk = 1'b0;
  logic rst_n;
  logic gaps_on;
  logic stalls_on;
  int unsigned bytes_sent;
  int unsigned settings_used;
  cipher_ledger ledger;

  lskc_in_if  in_ch();
  lskc_out_if out_ch();
  lskc_cfg_if cfg_ch();

  letter_shift_key_cipher_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("letter_shift_key_cipher_unit verification failed");
    $finish;
  end

  function automatic logic [SHIFTS_W-1:0] pack_shifts(input int e[8]);
    logic [SHIFTS_W-1:0] w;
    for (int i = 0; i < 8; i++) w[i*ENTRY_W +: ENTRY_W] = ENTRY_W'(e[i]);
    return w;
  endfunction

  function automatic logic [SHIFTS_W-1:0] random_shifts();
    logic [SHIFTS_W-1:0] w;
    w = SHIFTS_W'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 1) begin
      for (int i = 0; i < 8; i++) w[i*ENTRY_W +: ENTRY_W] = ENTRY_W'($urandom_range(0, 50) - 25);
    end
    return w;
  endfunction

  function automatic logic [BYTE_W-1:0] random_text_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return BYTE_W'($urandom_range(CHR_LC_A, CHR_LC_Z));
      4, 5, 6:    return BYTE_W'($urandom_range(CHR_UC_A, CHR_UC_Z));
      7:          return BYTE_W'($urandom_range(0, 255));
      8: begin
        case ($urandom_range(0, 7))
          0: return BYTE_W'(CHR_UC_A - 1);
          1: return BYTE_W'(CHR_UC_Z + 1);
          2: return BYTE_W'(CHR_LC_A - 1);
          3: return BYTE_W'(CHR_LC_Z + 1);
          4: return CHR_LC_A;
          5: return CHR_LC_Z;
          6: return CHR_UC_A;
          default: return CHR_UC_Z;
        endcase
      end
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return LEN_W'($urandom_range(17, 31));
      2: return LEN_W'(16);
      3: return LEN_W'(1);
      default: return LEN_W'($urandom_range(2, 15));
    endcase
  endfunction

  // block must be idle; upper data bits are junk to exercise masking
  task automatic program_key(input logic dec, input logic [LEN_W-1:0] len,
                             input logic [SHIFTS_W-1:0] lo, input logic [SHIFTS_W-1:0] hi);
    logic [CFG_DATA_W-1:0] word[4];
    word[0] = CFG_DATA_W'({$urandom, $urandom});
    word[0][0] = dec;
    word[1] = CFG_DATA_W'({$urandom, $urandom});
    word[1][LEN_W-1:0] = len;
    word[2] = lo;
    word[3] = hi;
    cfg_ch.valid <= 1'b1;
    for (int r = 0; r < 4; r++) begin
      cfg_ch.index <= cfg_reg_t'(r);
      cfg_ch.data  <= word[r];
      do @(posedge clk); while (!cfg_ch.ready);
      ledger.write_reg(cfg_reg_t'(r), word[r]);
    end
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic restart);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    ledger.note_input(b, restart);
    bytes_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic send_messages(input int unsigned count);
    int unsigned left;
    logic        restart;
    left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      if (left == 0) begin
        left = $urandom_range(1, 40);
        restart = ($urandom_range(0, 9) != 0);
      end else begin
        restart = ($urandom_range(0, 49) == 0);
      end
      push_byte(random_text_byte(), restart);
      left--;
    end
  endtask

  // receiver: random stall bursts while enabled
  initial begin
    int unsigned hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) ledger.check_result(out_ch.out_byte);
      if (hold > 0) hold--;
      else if (stalls_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 10);
      out_ch.ready <= (hold == 0);
    end
  end

  initial begin
    int unsigned random_sent;
    ledger        = new();
    bytes_sent    = 0;
    settings_used = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.restart <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_DECRYPT_MODE;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset key: identity, plus byte extremes and the letter range borders
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(CHR_LC_A, 1'b0);
    push_byte(CHR_LC_Z, 1'b0);
    push_byte(CHR_UC_A, 1'b0);
    push_byte(CHR_UC_Z, 1'b0);
    push_byte(BYTE_W'(CHR_UC_A - 1), 1'b0);
    push_byte(BYTE_W'(CHR_LC_Z + 1), 1'b0);
    drain();

    // full-length key with out-of-range entries
    program_key(1'b0, LEN_W'(16), pack_shifts('{31, -32, 25, -25, 1, -1, 0, 13}),
                pack_shifts('{26, -26, 12, -13, 5, 30, -31, 7}));
    push_byte(CHR_LC_Z, 1'b1);
    push_byte(CHR_LC_A, 1'b0);
    push_byte(CHR_UC_A, 1'b0);
    push_byte(CHR_UC_Z, 1'b0);
    push_byte(BYTE_W'(CHR_UC_Z + 1), 1'b1);  // restart on a non-letter
    push_byte("y", 1'b0);
    push_byte("b", 1'b0);
    push_byte("M", 1'b0);
    drain();

    // zero length acts as one
    program_key(1'b1, '0, pack_shifts('{-32, 3, 3, 3, 3, 3, 3, 3}), '0);
    push_byte("q", 1'b1);
    push_byte("B", 1'b0);
    drain();

    // oversize length saturates; leaves position at 3
    program_key(1'b1, LEN_W'(31), pack_shifts('{31, -32, 9, 4, 2, 2, 2, 2}),
                pack_shifts('{-1, -2, -3, -4, -5, -6, -7, -8}));
    push_byte("m", 1'b1);
    push_byte("Q", 1'b0);
    push_byte("x", 1'b0);
    drain();

    // length lowered below the held position, no restart
    program_key(1'b0, LEN_W'(2), pack_shifts('{11, -7, 1, 1, 1, 1, 1, 1}), '0);
    push_byte("k", 1'b0);
    push_byte("K", 1'b0);
    push_byte("a", 1'b0);
    drain();

    random_sent = 0;
    while (random_sent < 1700) begin
      if (random_sent >= 1400) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      program_key(1'($urandom_range(0, 1)), random_len(), random_shifts(), random_shifts());
      send_messages(40);
      drain();
      send_messages(45);
      random_sent += 85;
      drain();
    end
    in_ch.valid <= 1'b0;

    drain();
    repeat (4) @(posedge clk);
    $display("Sent %0d text bytes under %0d key settings, %0d output beats compared.",
             bytes_sent, settings_used, ledger.checked);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("letter_shift_key_cipher_unit verification clean");
    end else begin
      $display("letter_shift_key_cipher_unit verification failed");
    end
    $finish;
  end

endmodule
